@@ sv/ikhm_pkg.sv @@
// ----------------------------------------------------------------------------
// ikhm_pkg
// Shared constants, codes and types for the integer key hash map.
// ----------------------------------------------------------------------------
`default_nettype none
package ikhm_pkg;
  localparam int BUCKET_BITS = 7;
  localparam int WAYS = 4;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int QDEPTH = 2;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // One command word as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ikhm_item_t;

  typedef enum logic [3:0] {
    BK_CLEAR = 4'b0001,
    BK_IDLE  = 4'b0010,
    BK_READ  = 4'b0100,
    BK_EXEC  = 4'b1000
  } ikhm_bk_state_t;
endpackage
`default_nettype wire

@@ sv/ikhm_ram.sv @@
// ----------------------------------------------------------------------------
// ikhm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ikhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/ikhm_front.sv @@
// ----------------------------------------------------------------------------
// ikhm_front
// Input stage and short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module ikhm_front
  import ikhm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ikhm_item_t in_item,
  output logic            q_valid,
  input  wire logic       q_ready,
  output ikhm_item_t      q_item
);
  localparam int PB = $clog2(QDEPTH);
  ikhm_item_t buf_r [QDEPTH];
  logic [PB-1:0] wp_r, rp_r;
  logic [PB:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != (PB+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = buf_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  // Unused command codes are classified as lookups on entry.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r].cmd   <= (in_item.cmd == CMD_UNUSED) ? CMD_LOOKUP : in_item.cmd;
      buf_r[wp_r].key   <= in_item.key;
      buf_r[wp_r].value <= in_item.value;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PB+1)'(QDEPTH)) else $error("queue overflow");
  a_cmd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> q_item.cmd != CMD_UNUSED) else $error("unclassified command");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
`endif
endmodule
`default_nettype wire

@@ sv/ikhm_back.sv @@
// ----------------------------------------------------------------------------
// ikhm_back
// Bucket engine: reads one bucket row, compares all ways, updates the row.
// ----------------------------------------------------------------------------
`default_nettype none
module ikhm_back
  import ikhm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire ikhm_item_t q_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [31:0]     out_found_value
);
  ikhm_bk_state_t st_r, st_nxt;
  ikhm_item_t cur_r;
  logic [BUCKET_BITS-1:0] row;
  logic [KEY_W-1:0] rkey [WAYS];
  logic [VAL_W-1:0] rval [WAYS];
  logic [WAYS-1:0] hit, wr_en;
  logic [WAYS-1:0] rvld, vld_wdata;
  logic [BUCKET_BITS-1:0] clr_r, vld_waddr;
  logic vld_we, clearing;
  logic any_hit, has_free;
  logic [WAY_BITS-1:0] hit_w, free_w;
  logic [1:0] status_nxt;
  logic [31:0] found_nxt;
  logic exec;

  assign row = cur_r.key[BUCKET_BITS-1:0];
  assign q_ready = (st_r == BK_IDLE) && !out_valid;
  assign exec = (st_r == BK_EXEC);
  assign clearing = (st_r == BK_CLEAR);

  // One key and one value memory per way, addressed by bucket.
  for (genvar g = 0; g < WAYS; g++) begin : g_way
    ikhm_ram #(.WIDTH(KEY_W), .DEPTH(NUM_BUCKETS)) u_key (
      .clk(clk), .we(wr_en[g]), .waddr(row), .wdata(cur_r.key),
      .raddr(row), .rdata(rkey[g]));
    ikhm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BUCKETS)) u_val (
      .clk(clk), .we(wr_en[g]), .waddr(row), .wdata(cur_r.value),
      .raddr(row), .rdata(rval[g]));
    assign hit[g] = rvld[g] && (rkey[g] == cur_r.key);
  end

  // Valid marks of every bucket; cleared by a sweep after reset.
  ikhm_ram #(.WIDTH(WAYS), .DEPTH(NUM_BUCKETS)) u_vld (
    .clk(clk), .we(vld_we), .waddr(vld_waddr), .wdata(vld_wdata),
    .raddr(row), .rdata(rvld));

  assign vld_we = clearing || exec;
  assign vld_waddr = clearing ? clr_r : row;

  // Matching way and lowest free way.
  always_comb begin
    hit_w = '0;
    free_w = '0;
    has_free = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) hit_w = WAY_BITS'(w);
      if (!rvld[w]) begin
        free_w = WAY_BITS'(w);
        has_free = 1'b1;
      end
    end
    any_hit = |hit;
  end

  // Result and write decision for the current command.
  always_comb begin
    status_nxt = ST_NOT_FOUND;
    found_nxt = '0;
    wr_en = '0;
    unique case (cur_r.cmd)
      CMD_INSERT: begin
        if (any_hit) status_nxt = ST_DUPLICATE;
        else if (!has_free) status_nxt = ST_FULL;
        else begin
          status_nxt = ST_OK;
          wr_en[free_w] = exec;
        end
      end
      CMD_DELETE: begin
        if (any_hit) status_nxt = ST_OK;
      end
      default: begin
        if (any_hit) begin
          status_nxt = ST_OK;
          found_nxt = rval[hit_w];
        end
      end
    endcase
  end

  // Updated valid row for the current command, or zero during the sweep.
  always_comb begin
    vld_wdata = rvld;
    if (clearing) vld_wdata = '0;
    else begin
      if (cur_r.cmd == CMD_INSERT && !any_hit && has_free) vld_wdata[free_w] = 1'b1;
      if (cur_r.cmd == CMD_DELETE && any_hit) vld_wdata[hit_w] = 1'b0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_CLEAR: if (clr_r == '1) st_nxt = BK_IDLE;
      BK_IDLE: if (q_valid && q_ready) st_nxt = BK_READ;
      BK_READ: st_nxt = BK_EXEC;
      BK_EXEC: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cur_r <= q_item;
    if (exec) begin
      out_status <= status_nxt;
      out_found_value <= found_nxt;
    end
  end

  // Sequencer, sweep counter and output flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (exec) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_onehit: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> $onehot0(hit)) else $error("key present twice");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_READ |=> st_r == BK_EXEC) else $error("sequencer slip");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid) else $error("result lost");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_ready) else $error("command taken during sweep");
`endif
endmodule
`default_nettype wire

@@ sv/integer_key_hash_map_core.sv @@
// ----------------------------------------------------------------------------
// integer_key_hash_map_core
// Hash map from 32-bit keys to 32-bit values with fixed-size buckets.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per command (lookup, insert,
// delete) with key and value; the output channel returns one word per
// command with status and found value, in order.
// A front queue of two words accepts commands while the back engine works.
// The back engine reads one bucket row from per-way memories, compares all
// ways in parallel and updates the row; it takes no new command until the
// result of the last one has been taken, so it works on one word at a time,
// held back by the registered memory read and the single result register.
// On an idle block an accepted input word passes the queue and the read and
// execute states, then out_valid rises.
// After reset a sweep clears the valid marks of every bucket; the queue
// still takes two words meanwhile. When the receiver stalls, the result
// holds, the engine waits and the queue fills, then in_ready falls.
`default_nettype none
module integer_key_hash_map_core
  import ikhm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value
);
  ikhm_item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{cmd: in_cmd, key: in_key, value: in_value};

  ikhm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

  ikhm_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_value(out_found_value));
endmodule
`default_nettype wire

@@ tb/sv/integer_key_hash_map_core_tb.sv @@
// ----------------------------------------------------------------------------
// integer_key_hash_map_core_tb
// Self-checking bench: random lookup, insert and delete words against a
// behavioral copy of the bucketed map, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_key_hash_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ikhm_pkg::*;

  // Scoreboard: holds its own copy of the map and the queue of expected words.
  class hash_map_scoreboard;
    bit [ikhm_pkg::WAYS-1:0] row_used [ikhm_pkg::NUM_BUCKETS];
    bit [31:0] row_key [ikhm_pkg::NUM_BUCKETS][ikhm_pkg::WAYS];
    bit [31:0] row_val [ikhm_pkg::NUM_BUCKETS][ikhm_pkg::WAYS];
    bit [33:0] pending_results [$];
    int errors;

    function new();
      foreach (row_used[i]) row_used[i] = '0;
      errors = 0;
    endfunction

    // Apply one accepted command word and queue the result it must produce.
    function void note_command(bit [1:0] cmd, bit [31:0] key, bit [31:0] value);
      int row;
      int hit;
      int free;
      bit [1:0] status;
      bit [31:0] found;
      row = int'(key[ikhm_pkg::BUCKET_BITS-1:0]);
      hit = -1;
      free = -1;
      found = '0;
      for (int w = 0; w < ikhm_pkg::WAYS; w++) begin
        if (row_used[row][w] && row_key[row][w] == key && hit < 0) hit = w;
        if (!row_used[row][w] && free < 0) free = w;
      end
      if (cmd == ikhm_pkg::CMD_INSERT) begin
        if (hit >= 0) status = ikhm_pkg::ST_DUPLICATE;
        else if (free < 0) status = ikhm_pkg::ST_FULL;
        else begin
          row_key[row][free] = key;
          row_val[row][free] = value;
          row_used[row][free] = 1'b1;
          status = ikhm_pkg::ST_OK;
        end
      end else if (cmd == ikhm_pkg::CMD_DELETE) begin
        if (hit >= 0) begin
          row_used[row][hit] = 1'b0;
          status = ikhm_pkg::ST_OK;
        end else status = ikhm_pkg::ST_NOT_FOUND;
      end else begin
        // The unused code behaves as a lookup.
        if (hit >= 0) begin
          found = row_val[row][hit];
          status = ikhm_pkg::ST_OK;
        end else status = ikhm_pkg::ST_NOT_FOUND;
      end
      pending_results.push_back({status, found});
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_result(bit [1:0] status, bit [31:0] found);
      bit [33:0] exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $time, status, found);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (exp[33:32] !== status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp[33:32], status);
        errors++;
      end
      if (exp[31:0] !== found) begin
        $display("%0t: found_value expected %h actual %h", $time, exp[31:0], found);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic [31:0] in_key;
  logic [31:0] in_value;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_status;
  logic [31:0] out_found_value;

  hash_map_scoreboard sb;
  bit stim_done;
  bit [31:0] key_pool [16];

  integer_key_hash_map_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_found_value(out_found_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one command word after a random gap and wait until it is taken.
  // The task is entered and left at a falling edge.
  task automatic send_word(bit [1:0] cmd, bit [31:0] key, bit [31:0] value);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_command(cmd, key, value);
    @(negedge clk);
  endtask

  // Pick a key that mostly lands in a few crowded buckets.
  function automatic bit [31:0] pick_key();
    int r;
    bit [31:0] k;
    r = $urandom_range(0, 9);
    if (r < 6) return key_pool[$urandom_range(0, 15)];
    if (r < 8) begin
      k = $urandom;
      k[6:0] = ($urandom_range(0, 1) != 0) ? 7'd3 : 7'd7;
      return k;
    end
    return $urandom;
  endfunction

  // Stimulus.
  initial begin
    bit [1:0] cmd;
    sb = new();
    in_valid = 1'b0;
    in_cmd = '0;
    in_key = '0;
    in_value = '0;
    rst_n = 1'b0;
    stim_done = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 16; i++)
      key_pool[i] = {$urandom_range(0, 1) ? 25'h1FF_FFFF : 25'($urandom), 7'(i % 3 * 127 / 2)};

    // Directed: misses, extremes, zero value, duplicate, full bucket, unused code.
    send_word(CMD_LOOKUP, 32'h0, 32'h0);
    send_word(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_INSERT, 32'h0, 32'h0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_INSERT, 32'h0, 32'h1234_5678);
    for (int i = 1; i <= 4; i++) send_word(CMD_INSERT, 32'(i << 7), 32'hA500_0000 + 32'(i));
    send_word(CMD_LOOKUP, 32'h0000_0200, 32'h0);
    send_word(CMD_UNUSED, 32'h0000_0100, 32'h0);
    send_word(CMD_DELETE, 32'h0000_0100, 32'h0);
    send_word(CMD_INSERT, 32'h0000_0500, 32'h5);
    send_word(CMD_LOOKUP, 32'h0000_0500, 32'h0);
    send_word(CMD_DELETE, 32'h0000_0100, 32'h0);
    send_word(CMD_DELETE, 32'h0, 32'h0);
    send_word(CMD_UNUSED, 32'h0, 32'h0);
    send_word(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555);

    // Random: inserts, lookups and deletes on a pool of colliding keys.
    for (int n = 0; n < 1450; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_INSERT;
        4, 5, 6: cmd = CMD_LOOKUP;
        7, 8: cmd = CMD_DELETE;
        default: cmd = CMD_UNUSED;
      endcase
      send_word(cmd, pick_key(), $urandom_range(0, 15) == 0 ? 32'h0 : $urandom);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Result side: random stalls, sampled at the rising edge.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_status, out_found_value);
      @(negedge clk);
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("integer_key_hash_map_core_tb OK");
    else
      $display("integer_key_hash_map_core_tb NOT OK");
    $finish;
  end

  // Timeout.
  initial begin
    #5ms;
    $display("integer_key_hash_map_core_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
sv/ikhm_pkg.sv
sv/ikhm_ram.sv
sv/ikhm_front.sv
sv/ikhm_back.sv
sv/integer_key_hash_map_core.sv
tb/sv/integer_key_hash_map_core_tb.sv
